FILE: hdl/apvd_pkg.sv
package apvd_pkg;

   localparam int MAX_LAGS   = 1024;
   localparam int LAG_W      = $clog2(MAX_LAGS);
   localparam int CORR_W     = 32;
   localparam int TAG_W      = 16;
   localparam int THR_W      = 17;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = CORR_W + THR_W + 1;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(19661);
   localparam logic [LAG_W-1:0] LAG_LAST  = LAG_W'(MAX_LAGS - 1);

   // end-of-segment values handed from the tracker to the voicing stage
   typedef struct packed {
      logic [CORR_W-1:0] peak;
      logic [CORR_W-1:0] energy;
      logic [LAG_W-1:0]  peak_lag;
      logic [TAG_W-1:0]  tag;
   } seg_type;

endpackage

FILE: hdl/apvd_tracker.sv
module apvd_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [apvd_pkg::CORR_W-1:0]   req_corr_value,
   input  logic                          req_last_lag,
   input  logic [apvd_pkg::TAG_W-1:0]    req_segment_tag,
   output logic                          seg_valid,
   input  logic                          seg_stall,
   output apvd_pkg::seg_type             seg_data
);
   import apvd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [CORR_W-1:0] corr_ff;
   logic              last_ff;
   logic [TAG_W-1:0]  tag_ff;

   logic [LAG_W-1:0]  lag_ff, lag_in;
   logic [CORR_W-1:0] energy_ff, energy_in;
   logic [CORR_W-1:0] min_ff, min_in;
   logic [CORR_W-1:0] peak_ff, peak_in;
   logic [LAG_W-1:0]  plag_ff, plag_in;

   logic              seg_valid_ff, seg_valid_in;
   seg_type           seg_ff;

   logic              accept;
   logic              advance;

   // a non-final lag only updates state, so it never waits on the segment stage
   assign advance   = in_valid_ff && !(last_ff && seg_valid_ff && seg_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      energy_in = energy_ff;
      min_in    = min_ff;
      peak_in   = peak_ff;
      plag_in   = plag_ff;
      priority if (lag_ff == '0) begin
         energy_in = corr_ff;
         min_in    = corr_ff;
         peak_in   = corr_ff;
         plag_in   = '0;
      end else if ($signed(corr_ff) < $signed(min_ff)) begin
         // new strict minimum: restart the peak search here
         min_in  = corr_ff;
         peak_in = corr_ff;
         plag_in = lag_ff;
      end else if ($signed(corr_ff) > $signed(peak_ff)) begin
         peak_in = corr_ff;
         plag_in = lag_ff;
      end else begin
         plag_in = plag_ff;
      end

      lag_in = lag_ff;
      priority if (last_ff) begin
         lag_in = '0;
      end else if (lag_ff != LAG_LAST) begin
         lag_in = lag_ff + LAG_W'(1);
      end else begin
         lag_in = lag_ff;
      end
   end

   always_comb begin
      seg_valid_in = seg_valid_ff;
      if (advance && last_ff) begin
         seg_valid_in = 1'b1;
      end else if (!seg_stall) begin
         seg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         seg_valid_ff <= 1'b0;
         lag_ff       <= '0;
         energy_ff    <= '0;
         min_ff       <= '0;
         peak_ff      <= '0;
         plag_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         seg_valid_ff <= seg_valid_in;
         if (advance) begin
            lag_ff    <= lag_in;
            energy_ff <= energy_in;
            min_ff    <= min_in;
            peak_ff   <= peak_in;
            plag_ff   <= plag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         corr_ff <= req_corr_value;
         last_ff <= req_last_lag;
         tag_ff  <= req_segment_tag;
      end
      if (advance && last_ff) begin
         seg_ff.peak     <= peak_in;
         seg_ff.energy   <= energy_in;
         seg_ff.peak_lag <= plag_in;
         seg_ff.tag      <= tag_ff;
      end
   end

   assign seg_valid = seg_valid_ff;
   assign seg_data  = seg_ff;

endmodule

FILE: hdl/apvd_voicing.sv
module apvd_voicing (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [apvd_pkg::THR_W-1:0]    csr_voicing_threshold,
   input  logic                          seg_valid,
   output logic                          seg_stall,
   input  apvd_pkg::seg_type             seg_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [apvd_pkg::LAG_W-1:0]    rsp_pitch_period,
   output logic                          rsp_voiced,
   output logic [apvd_pkg::TAG_W-1:0]    rsp_result_tag
);
   import apvd_pkg::*;

   logic [THR_W-1:0]         thr_ff;

   logic                     prod_valid_ff, prod_valid_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [CORR_W-1:0]        peak_ff;
   logic                     energy_nz_ff;
   logic [LAG_W-1:0]         plag_ff;
   logic [TAG_W-1:0]         ptag_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LAG_W-1:0]         period_ff;
   logic                     voiced_ff, voiced_in;
   logic [TAG_W-1:0]         rtag_ff;

   logic signed [PROD_W-1:0] thr_ext;
   logic signed [PROD_W-1:0] energy_ext;
   logic signed [PROD_W-1:0] peak_scaled;
   logic                     prod_load;
   logic                     prod_advance;

   assign csr_ready = 1'b1;

   assign prod_advance = !rsp_valid_ff || !rsp_stall;
   assign seg_stall    = prod_valid_ff && !prod_advance;
   assign prod_load    = seg_valid && !seg_stall;

   // threshold * energy, exact in PROD_W bits
   assign thr_ext    = $signed({{(PROD_W - THR_W){1'b0}}, thr_ff});
   assign energy_ext = $signed({{(PROD_W - CORR_W){seg_data.energy[CORR_W-1]}},
                                seg_data.energy});
   assign prod_in    = thr_ext * energy_ext;

   // peak * 2^16, sign extended to the product width
   assign peak_scaled = $signed({{(PROD_W - CORR_W - FRAC_W){peak_ff[CORR_W-1]}},
                                 peak_ff, {FRAC_W{1'b0}}});
   assign voiced_in   = energy_nz_ff && (peak_scaled >= prod_ff);

   always_comb begin
      prod_valid_in = prod_valid_ff;
      if (prod_load) begin
         prod_valid_in = 1'b1;
      end else if (prod_advance) begin
         prod_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (prod_valid_ff && prod_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= THR_RESET;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_voicing_threshold;
         end
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_ff      <= prod_in;
         peak_ff      <= seg_data.peak;
         energy_nz_ff <= (seg_data.energy != '0);
         plag_ff      <= seg_data.peak_lag;
         ptag_ff      <= seg_data.tag;
      end
      if (prod_valid_ff && prod_advance) begin
         period_ff <= plag_ff;
         voiced_ff <= voiced_in;
         rtag_ff   <= ptag_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pitch_period = period_ff;
   assign rsp_voiced       = voiced_ff;
   assign rsp_result_tag   = rtag_ff;

endmodule

FILE: hdl/autocorr_pitch_voicing_detector.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   corr_value, last_lag, segment_tag
// rsp_      out        rsp_valid/rsp_stall   pitch_period, voiced, result_tag
// csr_      in         csr_valid/csr_ready   voicing_threshold (always ready)
//
// One lag value is taken every cycle while req_stall is low; non-final lags never wait
// on the result side. A final lag's result passes through the input register, min/peak
// tracking, threshold * energy multiply, then compare into the output register.
// Synchronous active-high reset clears all tracking state and loads the default threshold.
// A stalled result backs up through the pipeline; req_stall rises only when a final lag
// finds no free slot behind it.
module autocorr_pitch_voicing_detector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [apvd_pkg::CORR_W-1:0]   req_corr_value,
   input  logic                          req_last_lag,
   input  logic [apvd_pkg::TAG_W-1:0]    req_segment_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [apvd_pkg::LAG_W-1:0]    rsp_pitch_period,
   output logic                          rsp_voiced,
   output logic [apvd_pkg::TAG_W-1:0]    rsp_result_tag,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [apvd_pkg::THR_W-1:0]    csr_voicing_threshold
);
   import apvd_pkg::*;

   logic    seg_valid;
   logic    seg_stall;
   seg_type seg_data;

   apvd_tracker u_tracker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_corr_value  (req_corr_value),
      .req_last_lag    (req_last_lag),
      .req_segment_tag (req_segment_tag),
      .seg_valid       (seg_valid),
      .seg_stall       (seg_stall),
      .seg_data        (seg_data)
   );

   apvd_voicing u_voicing (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_voicing_threshold (csr_voicing_threshold),
      .seg_valid             (seg_valid),
      .seg_stall             (seg_stall),
      .seg_data              (seg_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_pitch_period      (rsp_pitch_period),
      .rsp_voiced            (rsp_voiced),
      .rsp_result_tag        (rsp_result_tag)
   );

endmodule

FILE: tb/autocorr_pitch_voicing_detector_test.sv
module autocorr_pitch_voicing_detector_test;
   timeunit 1ns;
   timeprecision 1ps;

   import apvd_pkg::*;

   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   typedef struct {
      logic [LAG_W-1:0] period;
      logic             voiced;
      logic [TAG_W-1:0] tag;
   } pitch_result_type;

   logic              clock                 = 1'b0;
   logic              reset                 = 1'b1;
   logic              req_valid             = 1'b0;
   logic              req_stall;
   logic [CORR_W-1:0] req_corr_value        = '0;
   logic              req_last_lag          = 1'b0;
   logic [TAG_W-1:0]  req_segment_tag       = '0;
   logic              rsp_valid;
   logic              rsp_stall             = 1'b0;
   logic [LAG_W-1:0]  rsp_pitch_period;
   logic              rsp_voiced;
   logic [TAG_W-1:0]  rsp_result_tag;
   logic              csr_valid             = 1'b0;
   logic              csr_ready;
   logic [THR_W-1:0]  csr_voicing_threshold = '0;

   // predictor state
   logic [THR_W-1:0]         threshold_shadow = THR_RESET;
   logic [LAG_W-1:0]         lag_pos          = '0;
   logic signed [CORR_W-1:0] seg_energy       = '0;
   logic signed [CORR_W-1:0] trough           = '0;
   logic signed [CORR_W-1:0] crest            = '0;
   logic [LAG_W-1:0]         crest_lag        = '0;
   pitch_result_type         pending_pitch[$];

   int unsigned req_gap_pct   = 0;
   int unsigned rsp_hold_pct  = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned cycle_count   = 0;
   int unsigned items_sent    = 0;
   int unsigned segments_sent = 0;
   int unsigned results_seen  = 0;
   int unsigned mismatches    = 0;

   autocorr_pitch_voicing_detector dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_corr_value        (req_corr_value),
      .req_last_lag          (req_last_lag),
      .req_segment_tag       (req_segment_tag),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_pitch_period      (rsp_pitch_period),
      .rsp_voiced            (rsp_voiced),
      .rsp_result_tag        (rsp_result_tag),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_voicing_threshold (csr_voicing_threshold)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_pitch.size());
         $display("[autocorr_pitch_voicing_detector] ERROR");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap(input int unsigned pct);
      if (pct == 0 || $urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 8);
      return $urandom_range(3, 1);
   endfunction

   function automatic int unsigned pick_length(input bit short_only);
      int unsigned roll;
      roll = $urandom_range(99);
      if (short_only || roll < 25) return $urandom_range(2, 1);
      if (roll < 85) return $urandom_range(16, 3);
      return $urandom_range(64, 17);
   endfunction

   function automatic void predict_lag(input logic [CORR_W-1:0] raw, input logic last,
                                       input logic [TAG_W-1:0] tag);
      logic signed [CORR_W-1:0] v;
      pitch_result_type         r;
      longint                   peak_scaled;
      longint                   energy_scaled;
      v = raw;
      if (lag_pos == 0) begin
         seg_energy = v;
         trough     = v;
         crest      = v;
         crest_lag  = '0;
      end else if (v < trough) begin
         // a new strict minimum restarts the peak search
         trough    = v;
         crest     = v;
         crest_lag = lag_pos;
      end else if (v > crest) begin
         crest     = v;
         crest_lag = lag_pos;
      end
      if (!last) begin
         if (lag_pos != LAG_LAST) lag_pos++;
         return;
      end
      peak_scaled   = longint'(crest) * 64'sd65536;
      energy_scaled = longint'(threshold_shadow) * longint'(seg_energy);
      r.period = crest_lag;
      r.voiced = (seg_energy != 0) && (peak_scaled >= energy_scaled);
      r.tag    = tag;
      pending_pitch.push_back(r);
      lag_pos = '0;
   endfunction

   task automatic send_lag(input logic [CORR_W-1:0] value, input logic last,
                           input logic [TAG_W-1:0] tag);
      int unsigned gap;
      gap = pick_gap(req_gap_pct);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_corr_value  <= value;
      req_last_lag    <= last;
      req_segment_tag <= tag;
      do @(posedge clock); while (req_stall);
      predict_lag(value, last, tag);
      items_sent++;
      if (last) segments_sent++;
   endtask

   task automatic send_values(input int vals[$], input logic [TAG_W-1:0] tag);
      int i;
      for (i = 0; i < vals.size(); i++)
         send_lag(CORR_W'(vals[i]), i == vals.size() - 1, tag);
   endtask

   // Random segment: mostly a pitch-like curve whose peak sits near the voicing boundary.
   task automatic send_segment(input int unsigned len);
      logic [TAG_W-1:0] tag;
      int unsigned      shape;
      int unsigned      turn;
      int unsigned      crest_at;
      int unsigned      i;
      longint           energy;
      longint           floor_val;
      longint           bound;
      longint           val;
      tag       = TAG_W'($urandom);
      shape     = $urandom_range(9);
      energy    = longint'($urandom_range(32'h3FFF_FFFF, 1));
      floor_val = -longint'($urandom_range(32'h3FFF_FFFF));
      bound     = longint'(threshold_shadow) * energy / 65536 + int'($urandom_range(4)) - 2;
      if (bound > 64'sh7FFF_FFFF) bound = 64'sh7FFF_FFFF;
      turn     = (len >= 3) ? $urandom_range(len - 2, 1) : 0;
      crest_at = (len >= 3) ? $urandom_range(len - 1, turn + 1) : 0;
      for (i = 0; i < len; i++) begin
         case (shape)
            6, 7: val = longint'($urandom);
            8: val = longint'($urandom_range(6)) - 3;
            9: begin
               case ($urandom_range(4))
                  0: val = 64'sh7FFF_FFFF;
                  1: val = -64'sh8000_0000;
                  2: val = 0;
                  3: val = 1;
                  default: val = -1;
               endcase
            end
            default: begin
               if (len < 3) val = longint'($urandom);
               else if (i == 0) val = energy;
               else if (i <= turn)
                  val = energy + (floor_val - energy) * longint'(i) / longint'(turn);
               else if (i == crest_at) val = bound;
               else val = bound - 1 - longint'($urandom_range(1000));
            end
         endcase
         send_lag(CORR_W'(val), i == len - 1, tag);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pitch.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      drain();
      csr_valid             <= 1'b1;
      csr_voicing_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      threshold_shadow = value;
   endtask

   task automatic check_result();
      pitch_result_type want;
      if (pending_pitch.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result with nothing pending: period %0d voiced %0d tag %h",
                     $realtime, rsp_pitch_period, rsp_voiced, rsp_result_tag);
         return;
      end
      want = pending_pitch.pop_front();
      results_seen++;
      if (rsp_pitch_period !== want.period || rsp_voiced !== want.voiced ||
          rsp_result_tag !== want.tag) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch period %0d/%0d voiced %0d/%0d tag %h/%h (expected/actual)",
                     $realtime, want.period, rsp_pitch_period, want.voiced, rsp_voiced,
                     want.tag, rsp_result_tag);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_hold_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (rsp_hold_left != 0) rsp_hold_left--;
         else rsp_hold_left = pick_gap(rsp_hold_pct);
         rsp_stall <= (rsp_hold_left != 0);
      end
   end

   // Runs at the reset threshold, so the default value is checked too.
   task automatic test_directed();
      int seg_vals[$];
      req_gap_pct  = 20;
      rsp_hold_pct = 20;
      send_lag(32'd100, 1'b1, 16'h0000);
      send_lag(32'd0, 1'b1, 16'hFFFF);
      send_lag(-32'sd5, 1'b1, 16'h00A5);
      send_lag(32'h7FFF_FFFF, 1'b1, 16'h5A5A);
      send_lag(32'h8000_0000, 1'b1, 16'hA5A5);
      seg_vals = '{1000, 600, 200, -300, 100, 400, 350};
      send_values(seg_vals, 16'h0101);
      // later strict minimum drops the earlier peak
      seg_vals = '{1000, 300, 500, -100, 200};
      send_values(seg_vals, 16'h0202);
      seg_vals = '{50, 50, 50, 50};
      send_values(seg_vals, 16'h0303);
      seg_vals = '{-1000, -2000, -500};
      send_values(seg_vals, 16'h0404);
   endtask

   task automatic test_threshold_extremes();
      logic [THR_W-1:0] thr_list[5];
      int               t;
      int               s;
      thr_list = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'h1FFFF};
      req_gap_pct  = 10;
      rsp_hold_pct = 30;
      for (t = 0; t < 5; t++) begin
         write_threshold(thr_list[t]);
         send_segment(1);
         for (s = 0; s < 3; s++) send_segment(pick_length(1'b0));
      end
   endtask

   task automatic test_random_segments();
      int unsigned gap_pcts[5];
      int unsigned hold_pcts[5];
      int unsigned target;
      int          p;
      gap_pcts  = '{0, 30, 60, 10, 0};
      hold_pcts = '{0, 30, 10, 60, 85};
      for (p = 0; p < 5; p++) begin
         case (p)
            2: write_threshold(THR_W'($urandom_range(131071, 65537)));
            4: write_threshold(THR_RESET);
            default: write_threshold(THR_W'($urandom_range(65536)));
         endcase
         req_gap_pct  = gap_pcts[p];
         rsp_hold_pct = hold_pcts[p];
         target = items_sent + 40;
         // last phase: short segments under heavy stall to back up the input side
         while (items_sent < target) send_segment(pick_length(p == 4));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_threshold_extremes();
      test_random_segments();
      drain();
      $display("%0d lag values in %0d segments sent, %0d pitch results checked, %0d mismatches",
               items_sent, segments_sent, results_seen, mismatches);
      $display("covered thresholds 0 to 131071, single-lag, tied, zero and negative energy %s",
               "segments under random input gaps and result stalls");
      if (mismatches == 0) begin
         $display("[autocorr_pitch_voicing_detector] OK");
      end else begin
         $display("[autocorr_pitch_voicing_detector] ERROR");
      end
      $finish;
   end

endmodule
